### src/npm_pkg.sv
// Package for the polynomial multiplier: sizes, widths, prime table, FSM state type.
// No dependencies; used by npm_reduce and ntt_polynomial_multiply.
package npm_pkg;

  localparam int LOG_SIZE  = 6;
  localparam int SIZE      = 1 << LOG_SIZE;
  localparam int HALF      = SIZE / 2;
  localparam int AW        = LOG_SIZE;
  localparam int CW        = $clog2(HALF + 1);
  localparam int COEF_W    = 30;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int ACC_W     = PROD_W + $clog2(HALF);
  localparam int RED_W     = ACC_W + (ACC_W % 2);
  localparam int RED_STEPS = RED_W / 2;
  localparam int STEP_W    = $clog2(RED_STEPS + 1);

  localparam logic [2:0] SEL_RESET = 3'd1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_MAC,
    ST_RED,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMPTY
  } npm_state_t;

  // Selector values above the table saturate to the last prime.
  function automatic logic [COEF_W-1:0] prime_of(input logic [2:0] sel);
    logic [COEF_W-1:0] p;
    case (sel)
      3'd0:    p = COEF_W'(7340033);
      3'd1:    p = COEF_W'(998244353);
      3'd2:    p = COEF_W'(754974721);
      3'd3:    p = COEF_W'(167772161);
      default: p = COEF_W'(469762049);
    endcase
    return p;
  endfunction

endpackage

### src/npm_reduce.sv
// Sequential modular reduction of a wide accumulator, two bits per cycle.
// Depends on npm_pkg.
module npm_reduce (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [npm_pkg::RED_W-1:0]     value,
  input  logic [npm_pkg::COEF_W-1:0]    modulus,
  output logic                          done,
  output logic [npm_pkg::COEF_W-1:0]    result
);
  import npm_pkg::*;

  logic [RED_W-1:0]  shift_r;
  logic [COEF_W-1:0] rem_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [COEF_W+1:0] t;
  logic [COEF_W+2:0] p1, p2, p3, d1, d2, d3;
  logic [COEF_W-1:0] rem_nxt;

  // remainder stays below p, so rem*4 + digit < 4p: at most three subtractions of p
  always_comb begin
    t  = {rem_r, shift_r[RED_W-1 -: 2]};
    p1 = {3'b000, modulus};
    p2 = {2'b00, modulus, 1'b0};
    p3 = p1 + p2;
    d1 = {1'b0, t} - p1;
    d2 = {1'b0, t} - p2;
    d3 = {1'b0, t} - p3;
    if (!d3[COEF_W+2])      rem_nxt = d3[COEF_W-1:0];
    else if (!d2[COEF_W+2]) rem_nxt = d2[COEF_W-1:0];
    else if (!d1[COEF_W+2]) rem_nxt = d1[COEF_W-1:0];
    else                    rem_nxt = t[COEF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(RED_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift_r <= value;
      rem_r   <= '0;
    end else if (busy_r) begin
      shift_r <= {shift_r[RED_W-3:0], 2'b00};
      rem_r   <= rem_nxt;
    end
  end

  assign done   = done_r;
  assign result = rem_r;

endmodule

### src/ntt_polynomial_multiply.sv
// Top level: operand memory, convolution sequencer, result store and output register.
// Depends on npm_pkg and npm_reduce.
//
// Loads up to 32 coefficients per operand (extra ones dropped) and, on the last item of the
// second operand, forms the product modulo the selected prime. Each output degree k is
// accumulated exactly with one shared 30x30 multiplier fed from the operand memory, then
// reduced modulo the prime by a 2-bit-per-cycle unit; the reduced coefficients go to a
// result memory and are then emitted up to the highest non-zero one, each being read from
// the result memory before it waits for the output register to be free.
// Input is not taken while a multiply runs. The stores need no clearing after reset.
module ntt_polynomial_multiply (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,     // prime_select
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // [29:0] coefficient, [31:30] zero
  input  logic        in_tuser,      // second_operand
  input  logic        in_tlast,      // last_of_operand
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // [29:0] product_coefficient, [31:30] zero
  output logic        out_tuser,     // product_empty
  output logic        out_tlast      // last_result
);
  import npm_pkg::*;

  // lower half: first operand, upper half: second operand
  logic [COEF_W-1:0] op_mem  [2*SIZE];
  logic [COEF_W-1:0] res_mem [SIZE];

  npm_state_t state_r, state_nxt;

  logic [2:0]        sel_r;
  logic [CW-1:0]     cnt_a_r, cnt_b_r;
  logic              phase_r;
  logic [COEF_W-1:0] p_r;
  logic [AW-1:0]     k_r, i_r, hi_r, top_r, e_r;
  logic              issuing_r, v1_r, v2_r, nz_r;
  logic [ACC_W-1:0]  acc_r;
  logic [PROD_W-1:0] prod_r;
  logic [COEF_W-1:0] a_rd_r, b_rd_r, res_rd_r;
  logic              out_valid_r, out_empty_r, out_last_r;
  logic [COEF_W-1:0] out_coef_r;

  logic              in_acc, load_first, load_second, go;
  logic              out_free, ops_empty, pipe_idle, k_at_max, nz_any;
  logic [CW:0]       kmax;
  logic [AW-1:0]     lo, hi;
  logic [AW:0]       wr_addr;
  logic              red_start, red_done;
  logic [COEF_W-1:0] red_res;

  assign in_acc      = in_tvalid & in_tready;
  assign load_first  = in_acc & !in_tuser & !phase_r & (cnt_a_r < CW'(HALF));
  assign load_second = in_acc & in_tuser & (cnt_b_r < CW'(HALF));
  assign go          = in_acc & in_tuser & in_tlast;
  assign out_free    = !out_valid_r | out_tready;
  assign ops_empty   = (cnt_a_r == '0) | (cnt_b_r == '0);
  assign kmax        = (CW+1)'(cnt_a_r) + (CW+1)'(cnt_b_r) - (CW+1)'(2);
  assign k_at_max    = ((CW+1)'(k_r) == kmax);
  assign pipe_idle   = !issuing_r & !v1_r & !v2_r;
  assign nz_any      = nz_r | (red_res != '0);
  assign wr_addr     = {in_tuser, in_tuser ? AW'(cnt_b_r) : AW'(cnt_a_r)};

  // index range of terms a[i]*b[k-i] for this degree
  always_comb begin
    if ((CW+1)'(k_r) >= (CW+1)'(cnt_b_r)) lo = k_r - AW'(cnt_b_r) + AW'(1);
    else                                  lo = '0;
    if ((CW+1)'(k_r) < (CW+1)'(cnt_a_r))  hi = k_r;
    else                                  hi = AW'(cnt_a_r) - AW'(1);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:      if (go) state_nxt = ST_SETUP;
      ST_SETUP:     state_nxt = ops_empty ? ST_EMPTY : ST_MAC;
      ST_MAC:       if (pipe_idle) state_nxt = ST_RED;
      ST_RED: begin
        if (red_done) begin
          if (!k_at_max)   state_nxt = ST_SETUP;
          else if (nz_any) state_nxt = ST_EMIT_RD;
          else             state_nxt = ST_EMPTY;
        end
      end
      ST_EMIT_RD:   state_nxt = ST_EMIT_WAIT;
      ST_EMIT_WAIT: if (out_free) state_nxt = (e_r == top_r) ? ST_LOAD : ST_EMIT_RD;
      ST_EMPTY:     if (out_free) state_nxt = ST_LOAD;
      default:      state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ST_LOAD);
    red_start = (state_r == ST_MAC) & pipe_idle;
  end

  npm_reduce u_reduce (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (red_start),
    .value   (RED_W'(acc_r)),
    .modulus (p_r),
    .done    (red_done),
    .result  (red_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      sel_r       <= SEL_RESET;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      phase_r     <= 1'b0;
      issuing_r   <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) sel_r <= cfg_wdata;
      if (load_first) cnt_a_r <= cnt_a_r + 1'b1;
      if (load_second) cnt_b_r <= cnt_b_r + 1'b1;
      if (in_acc & !in_tuser & !phase_r & in_tlast) phase_r <= 1'b1;
      if (state_nxt == ST_LOAD && state_r != ST_LOAD) begin
        cnt_a_r <= '0;
        cnt_b_r <= '0;
        phase_r <= 1'b0;
      end
      if (state_r == ST_SETUP) issuing_r <= !ops_empty;
      else if (state_r == ST_MAC && issuing_r && i_r == hi_r) issuing_r <= 1'b0;
      v1_r <= (state_r == ST_MAC) & issuing_r;
      v2_r <= v1_r;
      if ((state_r == ST_EMIT_WAIT || state_r == ST_EMPTY) && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_first | load_second) op_mem[wr_addr] <= in_tdata[COEF_W-1:0];
    if (go) begin
      p_r   <= prime_of(sel_r);
      k_r   <= '0;
      e_r   <= '0;
      nz_r  <= 1'b0;
      top_r <= '0;
    end
    if (state_r == ST_SETUP) begin
      i_r   <= lo;
      hi_r  <= hi;
      acc_r <= '0;
    end
    if (state_r == ST_MAC && issuing_r) begin
      a_rd_r <= op_mem[{1'b0, i_r}];
      b_rd_r <= op_mem[{1'b1, k_r - i_r}];
      i_r    <= i_r + 1'b1;
    end
    prod_r <= a_rd_r * b_rd_r;
    if (v2_r) acc_r <= acc_r + ACC_W'(prod_r);
    if (state_r == ST_RED && red_done) begin
      res_mem[k_r] <= red_res;
      if (red_res != '0) begin
        nz_r  <= 1'b1;
        top_r <= k_r;
      end
      k_r <= k_r + 1'b1;
    end
    if (state_r == ST_EMIT_RD) res_rd_r <= res_mem[e_r];
    if (state_r == ST_EMIT_WAIT && out_free) begin
      out_coef_r  <= res_rd_r;
      out_empty_r <= 1'b0;
      out_last_r  <= (e_r == top_r);
      e_r         <= e_r + 1'b1;
    end
    if (state_r == ST_EMPTY && out_free) begin
      out_coef_r  <= '0;
      out_empty_r <= 1'b1;
      out_last_r  <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_coef_r};
  assign out_tuser  = out_empty_r;
  assign out_tlast  = out_last_r;

endmodule
